/* rtl/utf8sd_pkg.sv */
package utf8sd_pkg;

  // width of the running codepoint and error counters (8 to 64)
  localparam int unsigned COUNT_WIDTH = 32;

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  localparam logic [20:0] MAX_CODEPOINT  = 21'h10FFFF;
  localparam logic [20:0] SURROGATE_LO   = 21'h00D800;
  localparam logic [20:0] SURROGATE_HI   = 21'h00DFFF;
  localparam logic [20:0] MIN_TWO_BYTE   = 21'h000080;
  localparam logic [20:0] MIN_THREE_BYTE = 21'h000800;
  localparam logic [20:0] MIN_FOUR_BYTE  = 21'h010000;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_DONE    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // byte sitting in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } stage_t;

  typedef struct packed {
    status_t     status;
    logic [20:0] codepoint;
    logic [1:0]  bytes_needed;
    logic [1:0]  partial_length;
    logic [31:0] decoded_count;
    logic [31:0] invalid_count;
  } result_t;

endpackage

/* rtl/utf8sd_ifs.sv */
interface utf8sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface utf8sd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [20:0] codepoint;
  logic [1:0]  bytes_needed;
  logic [1:0]  partial_length;
  logic [31:0] decoded_count;
  logic [31:0] invalid_count;

  modport source (output valid, output status, output codepoint, output bytes_needed,
                  output partial_length, output decoded_count, output invalid_count,
                  input ready);
  modport sink   (input valid, input status, input codepoint, input bytes_needed,
                  input partial_length, input decoded_count, input invalid_count,
                  output ready);
endinterface

/* rtl/utf8sd_in_reg.sv */
module utf8sd_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  utf8sd_in_if.sink         in_ch,
  input  logic              advance,
  output utf8sd_pkg::stage_t stage
);
  import utf8sd_pkg::*;

  stage_t stage_r;
  stage_t stage_nxt;
  logic   take;

  assign in_ch.ready = !stage_r.valid || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    stage_nxt = stage_r;
    if (take) begin
      stage_nxt.valid = 1'b1;
      stage_nxt.data  = in_ch.in_byte;
    end else if (advance) begin
      stage_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.data <= stage_nxt.data;
  end

  assign stage = stage_r;

endmodule

/* rtl/utf8sd_core.sv */
module utf8sd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  utf8sd_pkg::stage_t  stage,
  input  logic                advance,
  output utf8sd_pkg::result_t result
);
  import utf8sd_pkg::*;

  // partial sequence state
  logic [7:0] held_r [3];
  logic [7:0] held_nxt [3];
  logic [1:0] held_len_r, held_len_nxt;
  logic [2:0] exp_len_r, exp_len_nxt;
  count_t     dec_cnt_r, dec_cnt_nxt;
  count_t     err_cnt_r, err_cnt_nxt;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    priority if (b[7] == 1'b0)      return 3'd1;
    else if (b[7:5] == 3'b110)      return 3'd2;
    else if (b[7:4] == 4'b1110)     return 3'd3;
    else if (b[7:3] == 5'b11110)    return 3'd4;
    else                            return 3'd0;
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic [2:0]  lead;
    logic [2:0]  new_len;
    logic [20:0] v;
    logic        bad;
    status_t     st;
    logic [20:0] cp;
    logic [1:0]  need;

    b            = stage.data;
    lead         = lead_length(b);
    new_len      = {1'b0, held_len_r} + 3'd1;
    v            = '0;
    bad          = 1'b0;
    st           = ST_PENDING;
    cp           = '0;
    held_nxt     = held_r;
    held_len_nxt = held_len_r;
    exp_len_nxt  = exp_len_r;
    dec_cnt_nxt  = dec_cnt_r;
    err_cnt_nxt  = err_cnt_r;

    unique case (exp_len_r)
      3'd2:    v = {10'd0, held_r[0][4:0], b[5:0]};
      3'd3:    v = {5'd0, held_r[0][3:0], held_r[1][5:0], b[5:0]};
      default: v = {held_r[0][2:0], held_r[1][5:0], held_r[2][5:0], b[5:0]};
    endcase

    priority if (exp_len_r == 3'd2 && v < MIN_TWO_BYTE)   bad = 1'b1;
    else if (exp_len_r == 3'd3 && v < MIN_THREE_BYTE)     bad = 1'b1;
    else if (exp_len_r == 3'd4 && v < MIN_FOUR_BYTE)      bad = 1'b1;
    else if (v >= SURROGATE_LO && v <= SURROGATE_HI)      bad = 1'b1;
    else if (v > MAX_CODEPOINT)                           bad = 1'b1;
    else                                                  bad = 1'b0;

    priority if (held_len_r == 2'd0) begin
      priority if (lead == 3'd0) begin
        st          = ST_INVALID;
        err_cnt_nxt = err_cnt_r + 1'b1;
      end else if (lead == 3'd1) begin
        st          = ST_DONE;
        cp          = {13'd0, b};
        dec_cnt_nxt = dec_cnt_r + 1'b1;
        exp_len_nxt = 3'd0;
      end else begin
        held_nxt[0]  = b;
        held_len_nxt = 2'd1;
        exp_len_nxt  = lead;
      end
    end else if ((b & CONT_MASK) != CONT_TAG) begin
      // broken sequence, this byte is consumed too
      st           = ST_INVALID;
      err_cnt_nxt  = err_cnt_r + 1'b1;
      held_len_nxt = 2'd0;
      exp_len_nxt  = 3'd0;
    end else if (new_len >= exp_len_r) begin
      if (bad) begin
        st          = ST_INVALID;
        err_cnt_nxt = err_cnt_r + 1'b1;
      end else begin
        st          = ST_DONE;
        cp          = v;
        dec_cnt_nxt = dec_cnt_r + 1'b1;
      end
      held_len_nxt = 2'd0;
      exp_len_nxt  = 3'd0;
    end else begin
      for (int i = 1; i < 3; i++) begin
        if (held_len_r == 2'(i)) held_nxt[i] = b;
      end
      held_len_nxt = new_len[1:0];
    end

    need = '0;
    if (held_len_nxt != 2'd0 && {1'b0, held_len_nxt} < exp_len_nxt) begin
      need = 2'(exp_len_nxt - {1'b0, held_len_nxt});
    end

    result.status         = st;
    result.codepoint      = cp;
    result.bytes_needed   = need;
    result.partial_length = held_len_nxt;
    result.decoded_count  = 32'(dec_cnt_nxt);
    result.invalid_count  = 32'(err_cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_len_r <= '0;
      exp_len_r  <= '0;
      dec_cnt_r  <= '0;
      err_cnt_r  <= '0;
    end else if (advance) begin
      held_len_r <= held_len_nxt;
      exp_len_r  <= exp_len_nxt;
      dec_cnt_r  <= dec_cnt_nxt;
      err_cnt_r  <= err_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held_r <= held_nxt;
    end
  end

endmodule

/* rtl/utf8_stream_decoder_top.sv */
// Streaming UTF-8 decoder. One byte goes in per request on in_ch and exactly
// one result comes out per byte on out_ch, in order. An accepted byte sits in
// the input register until the result register is free or being emptied; its
// result is then loaded into the result register and offered on out_ch. The
// block sustains one byte per cycle as long as the result side keeps up.
// While a result waits, one more byte can still enter an empty input
// register. After that the input stalls until the waiting result is taken.
// The decode logic between the two registers folds the held lead and
// continuation bytes with the current one and applies the RFC 3629 checks
// (overlong forms, surrogates, values above U+10FFFF). Status 0 means more
// bytes are needed, 1 a codepoint is complete, 2 an invalid byte or
// sequence; an invalid continuation byte drops the partial sequence and is
// not retried as a lead. Counters of decoded codepoints and invalid events
// wrap and are cleared only by reset. No clearing pass after reset.
module utf8_stream_decoder_top (
  input  logic          clk,
  input  logic          rst_n,
  utf8sd_in_if.sink     in_ch,
  utf8sd_out_if.source  out_ch
);
  import utf8sd_pkg::*;

  stage_t  stage;
  result_t result;
  result_t res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    advance;

  // byte moves from the input register into the result register
  assign advance = stage.valid && (!out_valid_r || out_ch.ready);

  utf8sd_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  // decode state and per-byte logic
  utf8sd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .advance (advance),
    .result  (result)
  );

  // result register, held while the sink stalls
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = res_r.status;
  assign out_ch.codepoint      = res_r.codepoint;
  assign out_ch.bytes_needed   = res_r.bytes_needed;
  assign out_ch.partial_length = res_r.partial_length;
  assign out_ch.decoded_count  = res_r.decoded_count;
  assign out_ch.invalid_count  = res_r.invalid_count;

endmodule

/* rtl/utf8sd_checker.sv */
module utf8sd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [20:0] codepoint,
  input logic [1:0]  bytes_needed,
  input logic [1:0]  partial_length,
  input logic [31:0] decoded_count,
  input logic [31:0] invalid_count
);
  import utf8sd_pkg::*;

  // nothing comes out straight after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // codepoint is only non-zero on a completed sequence
  a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_DONE |-> codepoint == '0)
    else $error("codepoint set without completion");

  // an invalid event always leaves no partial sequence
  a_invalid_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_INVALID |-> partial_length == 2'd0 && bytes_needed == 2'd0)
    else $error("partial sequence kept after invalid event");

  // pending means a partial sequence is held and still short
  a_pending_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_PENDING |-> partial_length != 2'd0 && bytes_needed != 2'd0)
    else $error("pending result without partial sequence");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(codepoint)
      && $stable(decoded_count) && $stable(invalid_count))
    else $error("stalled result changed");

endmodule

bind utf8_stream_decoder_top utf8sd_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .status         (out_ch.status),
  .codepoint      (out_ch.codepoint),
  .bytes_needed   (out_ch.bytes_needed),
  .partial_length (out_ch.partial_length),
  .decoded_count  (out_ch.decoded_count),
  .invalid_count  (out_ch.invalid_count)
);
